// File: hdl/net_geometry_summary_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the net geometry summary modules
// Each macro checks one implication on the rising clock edge and is
// disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef NET_GEOMETRY_SUMMARY_DEFINES_SVH
`define NET_GEOMETRY_SUMMARY_DEFINES_SVH

// Same-cycle implication.
`define NGS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ngs assertion failed");

// Next-cycle implication.
`define NGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ngs assertion failed");

`endif

// File: hdl/ngs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngs_pkg
// Types, widths and helper functions of the net geometry summary block.
// ----------------------------------------------------------------------------
package ngs_pkg;

	localparam int COORD_BITS  = 32;
	localparam int COUNT_BITS  = 20;
	localparam int LENGTH_BITS = 48;
	localparam int NET_BITS    = 16;

	// Absolute coordinate differences need one extra bit.
	localparam int ROOT_BITS = COORD_BITS + 1;
	localparam int RAD_BITS  = 2 * ROOT_BITS;
	localparam int REM_BITS  = ROOT_BITS + 2;
	localparam int ITER_BITS = $clog2(ROOT_BITS);

	typedef enum logic [1:0] {
		MODE_PAD   = 2'd0,
		MODE_VIA   = 2'd1,
		MODE_TRACK = 2'd2,
		MODE_END   = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                         mode;
		logic [NET_BITS-1:0]           item_net;
		logic signed [COORD_BITS-1:0]  start_x;
		logic signed [COORD_BITS-1:0]  start_y;
		logic signed [COORD_BITS-1:0]  end_x;
		logic signed [COORD_BITS-1:0]  end_y;
		logic                          last;
	} item_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0]         pad_total;
		logic [COUNT_BITS-1:0]         via_total;
		logic [LENGTH_BITS-1:0]        track_length;
		logic                          box_valid;
		logic signed [COORD_BITS-1:0]  box_min_x;
		logic signed [COORD_BITS-1:0]  box_min_y;
		logic signed [COORD_BITS-1:0]  box_max_x;
		logic signed [COORD_BITS-1:0]  box_max_y;
	} result_t;

	// Classified request as it travels through the queue. A kind of MODE_END
	// means the item contributes nothing.
	typedef struct packed {
		mode_t                         kind;
		logic signed [COORD_BITS-1:0]  start_x;
		logic signed [COORD_BITS-1:0]  start_y;
		logic signed [COORD_BITS-1:0]  end_x;
		logic signed [COORD_BITS-1:0]  end_y;
		logic [ROOT_BITS-1:0]          abs_dx;
		logic [ROOT_BITS-1:0]          abs_dy;
		logic                          last;
	} entry_t;

	typedef struct packed {
		logic                          valid;
		logic signed [COORD_BITS-1:0]  min_x;
		logic signed [COORD_BITS-1:0]  min_y;
		logic signed [COORD_BITS-1:0]  max_x;
		logic signed [COORD_BITS-1:0]  max_y;
	} box_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_POINT1,
		BK_POINT2,
		BK_ROOT,
		BK_REPORT
	} back_state_t;

	function automatic box_t grow_box(box_t b, logic signed [COORD_BITS-1:0] x,
			logic signed [COORD_BITS-1:0] y);
		box_t r;
		r = b;
		if (!b.valid) begin
			r.valid = 1'b1;
			r.min_x = x;
			r.max_x = x;
			r.min_y = y;
			r.max_y = y;
		end else begin
			if (x < b.min_x) r.min_x = x;
			if (x > b.max_x) r.max_x = x;
			if (y < b.min_y) r.min_y = y;
			if (y > b.max_y) r.max_y = y;
		end
		return r;
	endfunction

endpackage

// File: hdl/ngs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngs_fifo
// Small register queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`include "net_geometry_summary_defines.svh"
module ngs_fifo #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	`NGS_ASSERT_IMPL(a_fifo_no_overflow, clk, arst_n, push, !full)
	`NGS_ASSERT_IMPL(a_fifo_no_underflow, clk, arst_n, pop, !empty)

endmodule

// File: hdl/ngs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngs_front
// Holds the target net, takes requests, classifies them and forms the
// absolute coordinate differences of track segments.
// ----------------------------------------------------------------------------
module ngs_front import ngs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  item_t               item,
	input  logic                cfg_we,
	input  logic [NET_BITS-1:0] cfg_wdata,
	input  logic                full,
	output logic                busy,
	output logic                push,
	output entry_t              push_data
);

	logic                on_target;
	logic [NET_BITS-1:0] target_net_q;
	logic                valid_s1;
	entry_t              entry_s1;
	entry_t              entry_d;
	logic                accept;

	function automatic logic [ROOT_BITS-1:0] abs_diff(logic signed [COORD_BITS-1:0] a,
			logic signed [COORD_BITS-1:0] b);
		logic [ROOT_BITS-1:0] d;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		return d[ROOT_BITS-1] ? (~d + 1'b1) : d;
	endfunction

	assign on_target = (item.item_net == target_net_q) && (item.mode != MODE_END);
	assign busy      = valid_s1 && full;
	assign accept    = start && !busy;
	assign push      = valid_s1 && !full;
	assign push_data = entry_s1;

	always_comb begin
		entry_d.kind    = on_target ? item.mode : MODE_END;
		entry_d.start_x = item.start_x;
		entry_d.start_y = item.start_y;
		entry_d.end_x   = item.end_x;
		entry_d.end_y   = item.end_y;
		entry_d.abs_dx  = abs_diff(item.start_x, item.end_x);
		entry_d.abs_dy  = abs_diff(item.start_y, item.end_y);
		entry_d.last    = item.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_net_q <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				target_net_q <= cfg_wdata;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

// File: hdl/ngs_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngs_isqrt
// Digit-by-digit integer square root, one root bit per clock cycle.
// ----------------------------------------------------------------------------
`include "net_geometry_summary_defines.svh"
module ngs_isqrt import ngs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [RAD_BITS-1:0]  radicand,
	output logic                 done,
	output logic [ROOT_BITS-1:0] root
);

	logic                 active_q;
	logic                 done_q;
	logic [ITER_BITS-1:0] iter_q;
	logic [RAD_BITS-1:0]  rad_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [REM_BITS-1:0]  rem_shift;
	logic [REM_BITS-1:0]  trial;
	logic                 take;

	assign rem_shift = {rem_q[REM_BITS-3:0], rad_q[RAD_BITS-1 -: 2]};
	assign trial     = {root_q, 2'b01};
	assign take      = (rem_shift >= trial);
	assign done      = done_q;
	assign root      = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			iter_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				iter_q   <= '0;
			end else if (active_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ITER_BITS'(ROOT_BITS - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (active_q) begin
			rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
			rem_q  <= take ? (rem_shift - trial) : rem_shift;
			root_q <= {root_q[ROOT_BITS-2:0], take};
		end
	end

	`NGS_ASSERT_IMPL(a_root_start_when_free, clk, arst_n, start, !active_q)
	`NGS_ASSERT_NEXT(a_root_done_ends_run, clk, arst_n, done_q, !done_q && !active_q)

endmodule

// File: hdl/ngs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngs_back
// Executes queued requests: counts, bounding box, track length and report.
// ----------------------------------------------------------------------------
`include "net_geometry_summary_defines.svh"
module ngs_back import ngs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    empty,
	input  entry_t  rd_data,
	output logic    pop,
	output logic    done,
	output result_t result
);

	back_state_t            state_q;
	back_state_t            state_d;
	entry_t                 entry_q;
	logic [COUNT_BITS-1:0]  pads_q;
	logic [COUNT_BITS-1:0]  vias_q;
	logic [LENGTH_BITS-1:0] len_q;
	box_t                   box_q;
	logic [RAD_BITS-1:0]    sq_x_q;
	logic [RAD_BITS-1:0]    sq_y_q;
	logic                   done_q;
	result_t                result_q;
	logic                   root_start;
	logic                   root_done;
	logic [ROOT_BITS-1:0]   root_val;
	logic [LENGTH_BITS:0]   len_sum;

	ngs_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sq_x_q + sq_y_q),
		.done     (root_done),
		.root     (root_val)
	);

	assign len_sum = {1'b0, len_q} + (LENGTH_BITS + 1)'(root_val);
	assign done    = done_q;
	assign result  = result_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:   if (!empty) state_d = BK_POINT1;
			BK_POINT1: state_d = (entry_q.kind == MODE_TRACK) ? BK_POINT2 : BK_REPORT;
			BK_POINT2: state_d = BK_ROOT;
			BK_ROOT:   if (root_done) state_d = BK_REPORT;
			BK_REPORT: state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		root_start = 1'b0;
		unique case (state_q)
			BK_IDLE:   pop = !empty;
			BK_POINT2: root_start = 1'b1;
			default: begin
				pop        = 1'b0;
				root_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			pads_q  <= '0;
			vias_q  <= '0;
			len_q   <= '0;
			box_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				BK_POINT1: begin
					if (entry_q.kind != MODE_END) begin
						box_q <= grow_box(box_q, entry_q.start_x, entry_q.start_y);
					end
					if (entry_q.kind == MODE_PAD && pads_q != '1) begin
						pads_q <= pads_q + 1'b1;
					end
					if (entry_q.kind == MODE_VIA && vias_q != '1) begin
						vias_q <= vias_q + 1'b1;
					end
				end
				BK_POINT2: box_q <= grow_box(box_q, entry_q.end_x, entry_q.end_y);
				BK_ROOT: begin
					if (root_done) begin
						len_q <= len_sum[LENGTH_BITS] ? '1 : len_sum[LENGTH_BITS-1:0];
					end
				end
				BK_REPORT: begin
					if (entry_q.last) begin
						done_q <= 1'b1;
						pads_q <= '0;
						vias_q <= '0;
						len_q  <= '0;
						box_q  <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_q <= rd_data;
		end
		if (state_q == BK_POINT1 && entry_q.kind == MODE_TRACK) begin
			sq_x_q <= RAD_BITS'(entry_q.abs_dx * entry_q.abs_dx);
			sq_y_q <= RAD_BITS'(entry_q.abs_dy * entry_q.abs_dy);
		end
		if (state_q == BK_REPORT && entry_q.last) begin
			result_q.pad_total    <= pads_q;
			result_q.via_total    <= vias_q;
			result_q.track_length <= len_q;
			result_q.box_valid    <= box_q.valid;
			result_q.box_min_x    <= box_q.min_x;
			result_q.box_min_y    <= box_q.min_y;
			result_q.box_max_x    <= box_q.max_x;
			result_q.box_max_y    <= box_q.max_y;
		end
	end

	`NGS_ASSERT_IMPL(a_clear_after_report, clk, arst_n, done_q,
		pads_q == '0 && vias_q == '0 && len_q == '0 && !box_q.valid)

endmodule

// File: hdl/net_geometry_summary.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// net_geometry_summary
// Per-net summary of pads, vias, track length and bounding box.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low; item
// carries the kind, net code, coordinates and the last flag. The target net
// is written through cfg_we / cfg_wdata; the user must do so only while no
// request is in flight, as the block itself does not enforce it. Requests
// of the target net count pads and vias, add the floor root of dx*dx + dy*dy
// of each track to the length and grow the bounding box. A request with last
// set reports the totals on result, marked by a one-cycle done strobe, and
// the totals then clear for the next set. The back end steps through POINT1
// and REPORT for a pad, via or end marker, and through POINT1, POINT2, ROOT
// and REPORT for a track; in ROOT it waits on the bit-serial square root unit,
// which sets the sustained rate for tracks. A queue of QUEUE_DEPTH requests
// lets the front keep taking requests while the back works; busy rises only
// when the queue and the front stage are both full.
// Reset clears the target net, the queue and all totals; nothing is pending.
// The receiver cannot stall; result is held until the next report.
// ----------------------------------------------------------------------------
module net_geometry_summary import ngs_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  item_t               item,
	output logic                busy,
	input  logic                cfg_we,
	input  logic [NET_BITS-1:0] cfg_wdata,
	output logic                done,
	output result_t             result
);

	logic   push;
	entry_t push_data;
	logic   pop;
	entry_t rd_data;
	logic   full;
	logic   empty;

	ngs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.full      (full),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	ngs_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH ($bits(entry_t))
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.pop     (pop),
		.rd_data (rd_data),
		.full    (full),
		.empty   (empty)
	);

	ngs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.rd_data (rd_data),
		.pop     (pop),
		.done    (done),
		.result  (result)
	);

endmodule

// File: test/net_geometry_summary_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// net_geometry_summary_test
// Drives sets of pads, vias, tracks and end markers into the block across
// several target nets. A scoreboard keeps its own running totals and
// bounding box, predicts each report and checks every done strobe.
// ----------------------------------------------------------------------------
module net_geometry_summary_test import ngs_pkg::*; ();

	localparam int DIFF_BITS     = COORD_BITS + 1;
	localparam int SETTLE_CYCLES = 150;
	localparam int SET_ITEMS     = 275;

	localparam logic signed [COORD_BITS-1:0] C_LO = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [COORD_BITS-1:0] C_HI = ~C_LO;

	// Running per-net totals and the queue of reports they lead to.
	class net_tally;
		logic [NET_BITS-1:0]          target;
		logic [COUNT_BITS-1:0]        pads_tally;
		logic [COUNT_BITS-1:0]        vias_tally;
		logic [LENGTH_BITS-1:0]       length_acc;
		logic                         box_seen;
		logic signed [COORD_BITS-1:0] lo_x, lo_y, hi_x, hi_y;
		result_t                      reports_due[$];
		int                           errors;

		function void clear_totals();
			pads_tally = '0;
			vias_tally = '0;
			length_acc = '0;
			box_seen   = 1'b0;
			lo_x = '0;
			lo_y = '0;
			hi_x = '0;
			hi_y = '0;
		endfunction

		function void widen_box(logic signed [COORD_BITS-1:0] x,
				logic signed [COORD_BITS-1:0] y);
			if (!box_seen) begin
				box_seen = 1'b1;
				lo_x = x;
				hi_x = x;
				lo_y = y;
				hi_y = y;
			end else begin
				if (x < lo_x) lo_x = x;
				if (x > hi_x) hi_x = x;
				if (y < lo_y) lo_y = y;
				if (y > hi_y) hi_y = y;
			end
		endfunction

		// Floor of the Euclidean length, one root bit per step from the top.
		function logic [LENGTH_BITS-1:0] hypot_floor(logic [DIFF_BITS-1:0] adx,
				logic [DIFF_BITS-1:0] ady);
			logic [2*DIFF_BITS-1:0] radicand;
			logic [2*DIFF_BITS-1:0] trial;
			logic [2*DIFF_BITS-1:0] root;
			radicand = adx * adx + ady * ady;
			root = '0;
			for (int b = DIFF_BITS - 1; b >= 0; b--) begin
				trial = root;
				trial[b] = 1'b1;
				if (trial * trial <= radicand) root = trial;
			end
			return root[LENGTH_BITS-1:0];
		endfunction

		function void fold_request(item_t req);
			logic signed [COORD_BITS:0] dx, dy;
			logic [DIFF_BITS-1:0]       adx, ady;
			logic [LENGTH_BITS:0]       sum;
			result_t                    rep;
			if (req.item_net == target && req.mode != MODE_END) begin
				case (req.mode)
					MODE_PAD: begin
						if (pads_tally != '1) pads_tally++;
						widen_box($signed(req.start_x), $signed(req.start_y));
					end
					MODE_VIA: begin
						if (vias_tally != '1) vias_tally++;
						widen_box($signed(req.start_x), $signed(req.start_y));
					end
					default: begin
						dx = $signed(req.start_x) - $signed(req.end_x);
						dy = $signed(req.start_y) - $signed(req.end_y);
						adx = dx[COORD_BITS] ? -dx : dx;
						ady = dy[COORD_BITS] ? -dy : dy;
						sum = length_acc + hypot_floor(adx, ady);
						length_acc = sum[LENGTH_BITS] ? '1 : sum[LENGTH_BITS-1:0];
						widen_box($signed(req.start_x), $signed(req.start_y));
						widen_box($signed(req.end_x), $signed(req.end_y));
					end
				endcase
			end
			if (req.last) begin
				rep.pad_total    = pads_tally;
				rep.via_total    = vias_tally;
				rep.track_length = length_acc;
				rep.box_valid    = box_seen;
				rep.box_min_x    = lo_x;
				rep.box_min_y    = lo_y;
				rep.box_max_x    = hi_x;
				rep.box_max_y    = hi_y;
				reports_due.insert(reports_due.size(), rep);
				clear_totals();
			end
		endfunction

		function void compare_field(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= 10)
					$display("report mismatch on %s: expected %0h, got %0h", field, want, got);
			end
		endfunction

		function void check_report(result_t got);
			result_t want;
			if (reports_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("report arrived with no request waiting for it");
			end else begin
				want = reports_due.pop_front();
				compare_field("pad_total", want.pad_total, got.pad_total);
				compare_field("via_total", want.via_total, got.via_total);
				compare_field("track_length", want.track_length, got.track_length);
				compare_field("box_valid", want.box_valid, got.box_valid);
				compare_field("box_min_x", want.box_min_x, got.box_min_x);
				compare_field("box_min_y", want.box_min_y, got.box_min_y);
				compare_field("box_max_x", want.box_max_x, got.box_max_x);
				compare_field("box_max_y", want.box_max_y, got.box_max_y);
			end
		endfunction

		function int pending();
			return reports_due.size();
		endfunction

		function int close_out();
			if (reports_due.size() != 0) begin
				errors += reports_due.size();
				$display("%0d expected reports never arrived", reports_due.size());
			end
			return errors;
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	item_t               item;
	logic                busy;
	logic                cfg_we;
	logic [NET_BITS-1:0] cfg_wdata;
	logic                done;
	result_t             result;

	net_tally board;
	int       sent;
	bit       steady;

	net_geometry_summary dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("net_geometry_summary test failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) board.check_report(result);
			if (start && !busy) board.fold_request(item);
		end
	end

	function automatic item_t make_item(mode_t mode, logic [NET_BITS-1:0] net,
			logic signed [COORD_BITS-1:0] sx, logic signed [COORD_BITS-1:0] sy,
			logic signed [COORD_BITS-1:0] ex, logic signed [COORD_BITS-1:0] ey,
			logic last);
		item_t it;
		it.mode     = mode;
		it.item_net = net;
		it.start_x  = sx;
		it.start_y  = sy;
		it.end_x    = ex;
		it.end_y    = ey;
		it.last     = last;
		return it;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return C_LO;
			1: return C_HI;
			2, 3, 4: return $urandom;
			default: return $urandom_range(0, 20000) - 10000;
		endcase
	endfunction

	function automatic item_t pick_item(logic last, bit on_target);
		item_t               it;
		logic [NET_BITS-1:0] net;
		mode_t               mode;
		case ($urandom_range(0, 9))
			0, 1, 2: mode = MODE_PAD;
			3, 4:    mode = MODE_VIA;
			5, 6, 7: mode = MODE_TRACK;
			default: mode = MODE_END;
		endcase
		if (on_target)
			net = board.target;
		else if ($urandom_range(0, 1))
			net = NET_BITS'($urandom_range(0, (1 << NET_BITS) - 1));
		else
			net = board.target ^ ({{(NET_BITS-1){1'b0}}, 1'b1} << $urandom_range(0, NET_BITS - 1));
		it = make_item(mode, net, pick_coord(), pick_coord(), pick_coord(), pick_coord(), last);
		// Now and then a track collapses to a single point.
		if (mode == MODE_TRACK && $urandom_range(0, 9) == 0) begin
			it.end_x = it.start_x;
			it.end_y = it.start_y;
		end
		return it;
	endfunction

	task automatic send_request(input item_t it);
		if (!steady && $urandom_range(0, 99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	// The extra edge lets the monitor record the request taken on this edge.
	task automatic drain(input int settle);
		start <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_target(input logic [NET_BITS-1:0] net);
		cfg_we    <= 1'b1;
		cfg_wdata <= net;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.target = net;
	endtask

	task automatic send_set();
		int kind;
		int len;
		kind = $urandom_range(0, 19);
		len  = (kind == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
		for (int i = 0; i < len; i++)
			send_request(pick_item(i == len - 1, kind != 1 && $urandom_range(0, 99) < 80));
	endtask

	task automatic run_phase(input logic [NET_BITS-1:0] net, input bit quiet,
			input bit pause_midway);
		int goal;
		write_target(net);
		steady = quiet;
		goal = sent + SET_ITEMS;
		while (sent < goal) begin
			send_set();
			if (pause_midway && sent >= goal - SET_ITEMS / 2) begin
				drain(0);
				pause_midway = 1'b0;
			end
		end
		drain(SETTLE_CYCLES);
		steady = 1'b0;
	endtask

	initial begin
		board = new;
		board.target = '0;
		board.errors = 0;
		board.clear_totals();
		sent   = 0;
		steady = 1'b0;
		start     <= 1'b0;
		item      <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		arst_n    <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_target('0);
		send_request(make_item(MODE_PAD, '0, C_LO, C_LO, C_HI, C_HI, 1'b0));
		send_request(make_item(MODE_VIA, '0, C_HI, C_HI, C_LO, C_LO, 1'b0));
		send_request(make_item(MODE_TRACK, '0, C_LO, C_LO, C_HI, C_HI, 1'b0));
		send_request(make_item(MODE_TRACK, '0, 5, -7, 5, -7, 1'b0));
		send_request(make_item(MODE_END, '0, 100000, -100000, C_LO, C_HI, 1'b0));
		// An off-target last request still closes the set.
		send_request(make_item(MODE_PAD, '1, 1, 1, 1, 1, 1'b1));
		send_request(make_item(MODE_END, '0, C_LO, C_HI, C_HI, C_LO, 1'b1));
		send_request(make_item(MODE_TRACK, NET_BITS'(1), C_LO, C_LO, C_HI, C_HI, 1'b1));
		send_request(make_item(MODE_TRACK, '0, C_HI, C_LO, C_LO, C_HI, 1'b0));
		send_request(make_item(MODE_TRACK, '0, 0, 0, 3, 4, 1'b0));
		send_request(make_item(MODE_VIA, '0, -1, -1, C_HI, C_LO, 1'b1));
		send_request(make_item(MODE_PAD, '0, 0, 0, C_LO, C_LO, 1'b1));
		drain(SETTLE_CYCLES);

		write_target('1);
		send_request(make_item(MODE_PAD, '1, C_HI, C_LO, 0, 0, 1'b0));
		send_request(make_item(MODE_TRACK, '1, -1, 0, 0, -1, 1'b0));
		send_request(make_item(MODE_END, '1, C_HI, C_HI, C_HI, C_HI, 1'b1));
		send_request(make_item(MODE_PAD, '0, 7, 7, 7, 7, 1'b1));
		drain(SETTLE_CYCLES);

		run_phase('1, 1'b0, 1'b0);
		run_phase(NET_BITS'($urandom_range(0, (1 << NET_BITS) - 1)), 1'b1, 1'b0);
		run_phase('0, 1'b0, 1'b1);
		run_phase(NET_BITS'($urandom_range(0, (1 << NET_BITS) - 1)), 1'b0, 1'b0);
		run_phase({1'b1, {(NET_BITS-1){1'b0}}}, 1'b0, 1'b0);
		run_phase(NET_BITS'($urandom_range(0, (1 << NET_BITS) - 1)), 1'b0, 1'b0);

		if (board.close_out() == 0)
			$display("net_geometry_summary test passed");
		else
			$display("net_geometry_summary test failed");
		$finish;
	end

endmodule
